// ===== hw/rtl/ccs_pkg.sv =====
`default_nettype none
package ccs_pkg;

    localparam int CW = 32;
    localparam int AW = 16;

    typedef enum logic {
        OP_SEGMENT = 1'b0,
        OP_FLUSH   = 1'b1
    } op_t;

    typedef struct packed {
        logic                  operation;
        logic                  not_first;
        logic                  last_in_branch;
        logic signed [CW-1:0]  in_start_x;
        logic signed [CW-1:0]  in_start_y;
        logic signed [CW-1:0]  in_start_z;
        logic signed [CW-1:0]  in_end_x;
        logic signed [CW-1:0]  in_end_y;
        logic signed [CW-1:0]  in_end_z;
    } in_word_t;

    typedef struct packed {
        logic signed [CW-1:0]  out_start_x;
        logic signed [CW-1:0]  out_start_y;
        logic signed [CW-1:0]  out_start_z;
        logic signed [CW-1:0]  out_end_x;
        logic signed [CW-1:0]  out_end_y;
        logic signed [CW-1:0]  out_end_z;
        logic signed [AW-1:0]  axis_x;
        logic signed [AW-1:0]  axis_y;
        logic signed [AW-1:0]  axis_z;
        logic [CW-1:0]         seg_length;
        logic                  zero_length;
    } out_word_t;

    // A finished segment handed from the front to the back.
    typedef struct packed {
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] sz;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
        logic signed [CW-1:0] ez;
    } seg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SQRT,
        ST_DIV,
        ST_DONE
    } back_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ccs_front.sv =====
`default_nettype none
module ccs_front
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire ccs_pkg::in_word_t in_data,
    output logic                  seg_valid,
    input  wire logic             seg_ready,
    output ccs_pkg::seg_t         seg_data
);

    logic pend_valid_reg, pend_valid_next;
    logic pend_nf_reg, pend_nf_next;
    logic pend_last_reg, pend_last_next;
    logic signed [ccs_pkg::CW-1:0] ps_reg [3];
    logic signed [ccs_pkg::CW-1:0] pe_reg [3];
    logic signed [ccs_pkg::CW-1:0] ps_next [3];
    logic signed [ccs_pkg::CW-1:0] pe_next [3];
    logic signed [ccs_pkg::CW-1:0] s_in [3];
    logic signed [ccs_pkg::CW-1:0] e_in [3];
    logic signed [ccs_pkg::CW-1:0] fin_end [3];
    logic signed [ccs_pkg::CW:0]   sum [3];
    logic is_flush;
    logic emits;
    logic accept;

    assign s_in[0] = in_data.in_start_x;
    assign s_in[1] = in_data.in_start_y;
    assign s_in[2] = in_data.in_start_z;
    assign e_in[0] = in_data.in_end_x;
    assign e_in[1] = in_data.in_end_y;
    assign e_in[2] = in_data.in_end_z;
    assign is_flush = (in_data.operation == ccs_pkg::OP_FLUSH);
    assign emits = pend_valid_reg;

    // An item that emits needs room in the queue.
    assign in_ready = !emits || seg_ready;
    assign accept = in_valid && in_ready;
    assign seg_valid = in_valid && emits;

    // Finished end: midpoint with the next start for a held middle segment.
    // Otherwise (nothing held, a flush, or a held first or last segment) the stored end is passed on as it stands.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum[k] = {pe_reg[k][ccs_pkg::CW-1], pe_reg[k]} + {s_in[k][ccs_pkg::CW-1], s_in[k]};
            if (pend_valid_reg && !is_flush && pend_nf_reg && !pend_last_reg)
                fin_end[k] = sum[k][ccs_pkg::CW:1];
            else
                fin_end[k] = pe_reg[k];
        end
    end

    assign seg_data = '{sx: ps_reg[0], sy: ps_reg[1], sz: ps_reg[2],
                        ex: fin_end[0], ey: fin_end[1], ez: fin_end[2]};

    // Pending segment update.
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_nf_next = pend_nf_reg;
        pend_last_next = pend_last_reg;
        for (int k = 0; k < 3; k++)
        begin
            ps_next[k] = ps_reg[k];
            pe_next[k] = pe_reg[k];
        end
        if (accept)
        begin
            if (is_flush)
            begin
                pend_valid_next = 1'b0;
            end
            else
            begin
                pend_valid_next = 1'b1;
                pend_nf_next = in_data.not_first;
                pend_last_next = in_data.last_in_branch;
                for (int k = 0; k < 3; k++)
                begin
                    ps_next[k] = in_data.not_first ? fin_end[k] : s_in[k];
                    pe_next[k] = e_in[k];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_nf_reg <= 1'b0;
            pend_last_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                ps_reg[k] <= '0;
                pe_reg[k] <= '0;
            end
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            pend_nf_reg <= pend_nf_next;
            pend_last_reg <= pend_last_next;
            for (int k = 0; k < 3; k++)
            begin
                ps_reg[k] <= ps_next[k];
                pe_reg[k] <= pe_next[k];
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ccs_queue.sv =====
`default_nettype none
module ccs_queue
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_valid,
    output logic               wr_ready,
    input  wire ccs_pkg::seg_t wr_data,
    output logic               rd_valid,
    input  wire logic          rd_ready,
    output ccs_pkg::seg_t      rd_data
);

    // Two-entry queue between front and back.
    ccs_pkg::seg_t mem_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign push = wr_valid && wr_ready;
    assign pop = rd_valid && rd_ready;
    assign rd_data = mem_reg[rp_reg];

    always_comb
    begin
        wp_next = push ? ~wp_reg : wp_reg;
        rp_next = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ccs_back.sv =====
`default_nettype none
module ccs_back
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          seg_valid,
    output logic               seg_ready,
    input  wire ccs_pkg::seg_t seg_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output ccs_pkg::out_word_t out_data
);

    localparam int CW = ccs_pkg::CW;
    localparam int DW = CW + 1;           // difference magnitude width
    localparam int SW = 2 * DW + 2;       // sum of squares width
    localparam int RW = CW + 2;           // root width
    localparam int RBW = $clog2(RW + 1);
    localparam int AW_X = ccs_pkg::AW;

    ccs_pkg::back_state_t state_reg, state_next;

    ccs_pkg::seg_t        seg_reg;
    logic [DW-1:0]        mag_reg [3];
    logic                 neg_reg [3];
    logic [SW-1:0]        sum_reg, sum_next;
    logic [1:0]           k_reg, k_next;
    logic [RW-1:0]        root_reg, root_next;
    logic [RBW-1:0]       bit_reg, bit_next;
    logic [RW:0]          rem_reg, rem_next;
    logic [4:0]           it_reg, it_next;
    logic [15:0]          q_reg, q_next;
    logic [AW_X-1:0]      ax_reg [3];
    logic                 ovalid_reg;
    ccs_pkg::out_word_t   odata_reg;

    logic signed [CW:0]   diff [3];
    logic [DW-1:0]        msel;
    logic [2*DW-1:0]      sq;
    logic [RW-1:0]        trial;
    logic [2*RW-1:0]      tsq;
    logic [RW:0]          rsh;
    logic                 ge;
    logic [15:0]          amag;
    logic [AW_X-1:0]      aval;
    logic                 take;

    assign seg_ready = (state_reg == ccs_pkg::ST_IDLE);
    assign take = seg_valid && seg_ready;
    assign diff[0] = {seg_data.ex[CW-1], seg_data.ex} - {seg_data.sx[CW-1], seg_data.sx};
    assign diff[1] = {seg_data.ey[CW-1], seg_data.ey} - {seg_data.sy[CW-1], seg_data.sy};
    assign diff[2] = {seg_data.ez[CW-1], seg_data.ez} - {seg_data.sz[CW-1], seg_data.sz};

    // Shared datapath pieces: one square, one root trial, one divide step.
    always_comb
    begin
        msel = mag_reg[k_reg];
        sq = msel * msel;
        trial = root_reg | (RW'(1) << bit_reg);
        tsq = trial * trial;
        rsh = {rem_reg[RW-1:0], 1'b0};
        ge = (rsh >= {1'b0, root_reg});
        amag = (q_reg + 16'd1) >> 1;
        aval = neg_reg[k_reg] ? AW_X'(17'h10000 - {1'b0, amag}) : AW_X'(amag);
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ccs_pkg::ST_IDLE:
                if (take)
                    state_next = ccs_pkg::ST_SQUARE;
            ccs_pkg::ST_SQUARE:
                if (k_reg == 2'd2)
                    state_next = ccs_pkg::ST_SQRT;
            ccs_pkg::ST_SQRT:
                if (bit_reg == '0)
                    state_next = ccs_pkg::ST_DIV;
            ccs_pkg::ST_DIV:
                if (root_reg == '0 || (k_reg == 2'd2 && it_reg == 5'd16))
                    state_next = ccs_pkg::ST_DONE;
            ccs_pkg::ST_DONE:
                if (!ovalid_reg || out_ready)
                    state_next = ccs_pkg::ST_IDLE;
            default:
                state_next = ccs_pkg::ST_IDLE;
        endcase
    end

    // Datapath register updates.
    always_comb
    begin
        sum_next = sum_reg;
        k_next = k_reg;
        root_next = root_reg;
        bit_next = bit_reg;
        rem_next = rem_reg;
        it_next = it_reg;
        q_next = q_reg;
        case (state_reg)
            ccs_pkg::ST_IDLE:
            begin
                sum_next = '0;
                k_next = '0;
            end
            ccs_pkg::ST_SQUARE:
            begin
                sum_next = sum_reg + SW'(sq);
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd2)
                begin
                    k_next = '0;
                    root_next = '0;
                    bit_next = RBW'(RW - 1);
                end
            end
            ccs_pkg::ST_SQRT:
            begin
                if (SW'(tsq) <= sum_reg && (2*RW <= SW || tsq <= (2*RW)'(sum_reg)))
                    root_next = trial;
                bit_next = bit_reg - RBW'(1);
                if (bit_reg == '0)
                begin
                    it_next = '0;
                    q_next = '0;
                    rem_next = (RW+1)'(mag_reg[0]);
                end
            end
            ccs_pkg::ST_DIV:
            begin
                if (it_reg == 5'd0)
                begin
                    if (rem_reg >= {1'b0, root_reg})
                    begin
                        rem_next = rem_reg - {1'b0, root_reg};
                        q_next = 16'd1;
                    end
                    else
                    begin
                        q_next = 16'd0;
                    end
                    it_next = 5'd1;
                end
                else if (it_reg == 5'd16)
                begin
                    it_next = '0;
                    q_next = '0;
                    // The last component leaves the index in range.
                    if (k_reg != 2'd2)
                    begin
                        k_next = k_reg + 2'd1;
                        rem_next = (RW+1)'(mag_reg[k_reg + 2'd1]);
                    end
                end
                else
                begin
                    rem_next = ge ? rsh - {1'b0, root_reg} : rsh;
                    q_next = {q_reg[14:0], ge};
                    it_next = it_reg + 5'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            seg_reg <= seg_data;
            for (int k = 0; k < 3; k++)
            begin
                neg_reg[k] <= diff[k][CW];
                mag_reg[k] <= diff[k][CW] ? DW'(-diff[k]) : DW'(diff[k]);
                ax_reg[k] <= '0;
            end
        end
        else if (state_reg == ccs_pkg::ST_DIV && it_reg == 5'd16)
        begin
            ax_reg[k_reg] <= aval;
        end
        sum_reg <= sum_next;
        k_reg <= k_next;
        root_reg <= root_next;
        bit_reg <= bit_next;
        rem_reg <= rem_next;
        it_reg <= it_next;
        q_reg <= q_next;
    end

    // Output register; the back part refills it once taken.
    always_ff @(posedge clk)
    begin
        if (state_reg == ccs_pkg::ST_DONE && (!ovalid_reg || out_ready))
        begin
            odata_reg.out_start_x <= seg_reg.sx;
            odata_reg.out_start_y <= seg_reg.sy;
            odata_reg.out_start_z <= seg_reg.sz;
            odata_reg.out_end_x <= seg_reg.ex;
            odata_reg.out_end_y <= seg_reg.ey;
            odata_reg.out_end_z <= seg_reg.ez;
            odata_reg.axis_x <= ax_reg[0];
            odata_reg.axis_y <= ax_reg[1];
            odata_reg.axis_z <= ax_reg[2];
            odata_reg.seg_length <= (root_reg[RW-1:CW] != '0) ? '1 : root_reg[CW-1:0];
            odata_reg.zero_length <= (root_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ccs_pkg::ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ccs_pkg::ST_DONE && (!ovalid_reg || out_ready))
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_data = odata_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/cylinder_chain_smoother.sv =====
`default_nettype none
// Cylinder chain smoother. Segments enter in branch order with first and
// last flags; one segment is held pending until the next word (or a flush
// word) arrives, then its smoothed ends, length and unit axis come out as one
// word. The front part accepts a word per cycle while the two-entry queue
// has room; the back part squares the differences, takes the bit-by-bit
// square root and runs the three axis divisions on one shared unit, and
// takes no new segment until the last one has gone into its output register.
module cylinder_chain_smoother
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ccs_pkg::in_word_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ccs_pkg::out_word_t     out_data
);

    logic          f_valid, f_ready, b_valid, b_ready;
    ccs_pkg::seg_t f_data, b_data;

    ccs_front u_front
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .seg_valid(f_valid), .seg_ready(f_ready), .seg_data(f_data)
    );

    ccs_queue u_queue
    (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
    );

    ccs_back u_back
    (
        .clk(clk), .rst_n(rst_n),
        .seg_valid(b_valid), .seg_ready(b_ready), .seg_data(b_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

endmodule
`default_nettype wire

// ===== verif/cylinder_chain_smoother_tb.sv =====
`default_nettype none
module cylinder_chain_smoother_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    ccs_pkg::in_word_t  in_data;
    logic               out_valid;
    logic               out_ready;
    ccs_pkg::out_word_t out_data;

    // Idle percentages for the sender and the receiver, set per phase.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    // Results the block still owes, oldest first.
    ccs_pkg::out_word_t segment_results_q[$];
    int unsigned mismatch_cnt = 0;
    int unsigned quiet_cycles;

    // Shadow copy of the held segment.
    bit      held_valid;
    longint  held_start[3];
    longint  held_end[3];
    bit      held_not_first;
    bit      held_last;

    cylinder_chain_smoother uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Length and axis of the held segment, appended to the expected results.
    function automatic void finish_held_segment();
        ccs_pkg::out_word_t r;
        longint      d;
        logic [63:0] mag[3];
        bit          neg[3];
        logic [127:0] sum;
        logic [127:0] t;
        logic [63:0] root;
        logic [63:0] q;
        logic [63:0] rem;
        logic [15:0] a;
        sum = '0;
        for (int k = 0; k < 3; k++)
        begin
            d = held_end[k] - held_start[k];
            neg[k] = d < 0;
            mag[k] = neg[k] ? -d : d;
            sum += 128'(mag[k]) * 128'(mag[k]);
        end
        // Bit-by-bit integer square root of the squared length.
        root = '0;
        for (int b = 33; b >= 0; b--)
        begin
            t = 128'(root | (64'd1 << b));
            if (t * t <= sum)
                root = t[63:0];
        end
        r.out_start_x = held_start[0][31:0];
        r.out_start_y = held_start[1][31:0];
        r.out_start_z = held_start[2][31:0];
        r.out_end_x   = held_end[0][31:0];
        r.out_end_y   = held_end[1][31:0];
        r.out_end_z   = held_end[2][31:0];
        for (int k = 0; k < 3; k++)
        begin
            a = '0;
            if (root != 0)
            begin
                // One extra quotient bit, then round half up.
                rem = mag[k];
                q = '0;
                for (int i = 0; i < 16; i++)
                begin
                    if (i > 0)
                    begin
                        rem = rem << 1;
                        q = q << 1;
                    end
                    if (rem >= root)
                    begin
                        rem = rem - root;
                        q[0] = 1'b1;
                    end
                end
                a = 16'((q + 1) >> 1);
                if (neg[k])
                    a = -a;
            end
            if (k == 0) r.axis_x = a;
            else if (k == 1) r.axis_y = a;
            else r.axis_z = a;
        end
        r.seg_length  = (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
        r.zero_length = (root == 0);
        segment_results_q = {segment_results_q, r};
    endfunction

    // Advance the shadow state by one accepted word.
    function automatic void predict_word(ccs_pkg::in_word_t w);
        longint s[3];
        longint e[3];
        s[0] = w.in_start_x; s[1] = w.in_start_y; s[2] = w.in_start_z;
        e[0] = w.in_end_x;   e[1] = w.in_end_y;   e[2] = w.in_end_z;
        if (w.operation == ccs_pkg::OP_FLUSH)
        begin
            if (held_valid)
                finish_held_segment();
            held_valid = 1'b0;
            return;
        end
        if (held_valid)
        begin
            // A middle segment ends halfway to the next original start.
            if (held_not_first && !held_last)
                for (int k = 0; k < 3; k++)
                    held_end[k] = (held_end[k] + s[k]) >>> 1;
            finish_held_segment();
        end
        held_not_first = w.not_first;
        held_last = w.last_in_branch;
        for (int k = 0; k < 3; k++)
        begin
            held_start[k] = w.not_first ? held_end[k] : s[k];
            held_end[k] = e[k];
        end
        held_valid = 1'b1;
    endfunction

    task automatic send_word(ccs_pkg::in_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        predict_word(w);
    endtask

    task automatic send_segment(bit nf, bit last, int sx, int sy, int sz,
                                int ex, int ey, int ez);
        ccs_pkg::in_word_t w;
        w.operation = ccs_pkg::OP_SEGMENT;
        w.not_first = nf;
        w.last_in_branch = last;
        w.in_start_x = sx; w.in_start_y = sy; w.in_start_z = sz;
        w.in_end_x = ex;   w.in_end_y = ey;   w.in_end_z = ez;
        send_word(w);
    endtask

    // Flush words carry random coordinates that the block must ignore.
    task automatic send_flush();
        ccs_pkg::in_word_t w;
        logic [223:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        w = raw[$bits(ccs_pkg::in_word_t)-1:0];
        w.operation = ccs_pkg::OP_FLUSH;
        send_word(w);
    endtask

    // Hold the input idle until every expected word has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (segment_results_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic int near_value(int base);
        case ($urandom_range(5))
            0: return int'($urandom);
            1: return base;
            2: return base + int'($urandom_range(3)) - 1;
            default: return base + int'($urandom_range(32'h0003_FFFF)) - 32'sh0001_FFFF;
        endcase
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("%s: expected %h, got %h", name, exp_v, act_v);
        end
    endtask

    // Receiver side: random stalls, and every accepted word checked in order.
    always @(posedge clk)
    begin
        ccs_pkg::out_word_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (out_valid && out_ready)
            begin
                if (segment_results_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected output word %h", out_data);
                end
                else
                begin
                    e = segment_results_q.pop_front();
                    check_field("out_start_x", e.out_start_x, out_data.out_start_x);
                    check_field("out_start_y", e.out_start_y, out_data.out_start_y);
                    check_field("out_start_z", e.out_start_z, out_data.out_start_z);
                    check_field("out_end_x", e.out_end_x, out_data.out_end_x);
                    check_field("out_end_y", e.out_end_y, out_data.out_end_y);
                    check_field("out_end_z", e.out_end_z, out_data.out_end_z);
                    check_field("axis_x", 32'(e.axis_x), 32'(out_data.axis_x));
                    check_field("axis_y", 32'(e.axis_y), 32'(out_data.axis_y));
                    check_field("axis_z", 32'(e.axis_z), 32'(out_data.axis_z));
                    check_field("seg_length", e.seg_length, out_data.seg_length);
                    check_field("zero_length", 32'(e.zero_length),
                                32'(out_data.zero_length));
                end
            end
        end
    end

    // Watchdog on cycles with no word moving on either side.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("cylinder_chain_smoother: mismatch");
                $finish;
            end
        end
    end

    // Flush on empty, a not-first word with no predecessor, extremes.
    task automatic test_directed();
        send_flush();
        send_segment(1, 0, 5, 6, 7, 32'h0001_0000, 0, 0);
        send_segment(0, 0, 0, 0, 0, 0, 0, 0);
        send_segment(1, 0, 9, 9, 9, 0, 0, 0);
        send_segment(1, 1, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_segment(0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_segment(0, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_segment(0, 0, 0, 0, 0, 32'h0003_0000, 32'hFFFC_0000, 0);
        send_segment(1, 0, 0, 0, 0, 32'h0006_0000, 0, 32'h0002_0000);
        send_segment(1, 0, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFD,
                     32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        // A middle segment flushed keeps its own end.
        send_flush();
        send_flush();
        // A not-first segment after a flushed middle one takes the stored end.
        send_segment(1, 0, 3, 3, 3, 32'h0002_0000, 0, 0);
        send_flush();
        send_segment(0, 0, 0, 0, 0, 0, 0, 1);
        send_segment(1, 1, 0, 0, 0, 32'hFFFF_FFFF, 0, 0);
        send_segment(1, 1, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0);
        send_flush();
        drain();
    endtask

    // Branches of random length with coordinates that mostly follow on.
    task automatic test_random_branches(int unsigned n_words);
        int unsigned sent;
        int unsigned len;
        int p[3];
        int q[3];
        sent = 0;
        p[0] = int'($urandom); p[1] = int'($urandom); p[2] = int'($urandom);
        while (sent < n_words)
        begin
            if ($urandom_range(9) == 0)
            begin
                // Noise: any flags, any coordinates, or a flush.
                if ($urandom_range(1) != 0)
                    send_flush();
                else
                    send_segment(1'($urandom_range(1)), 1'($urandom_range(1)),
                                 int'($urandom), int'($urandom), int'($urandom),
                                 int'($urandom), int'($urandom), int'($urandom));
                sent++;
                continue;
            end
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
            begin
                for (int k = 0; k < 3; k++)
                    q[k] = ($urandom_range(15) == 0) ? p[k] : near_value(p[k]);
                send_segment(i != 0, i == len - 1, near_value(p[0]), near_value(p[1]),
                             near_value(p[2]), q[0], q[1], q[2]);
                p = q;
                sent++;
            end
            if ($urandom_range(7) == 0)
            begin
                send_flush();
                sent++;
            end
        end
        send_flush();
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        held_valid = 1'b0;
        held_not_first = 1'b0;
        held_last = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            held_start[k] = 0;
            held_end[k] = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_branches(160);
        send_idle_pct = 56;
        test_random_branches(160);
        send_idle_pct = 0;
        recv_stall_pct = 56;
        test_random_branches(160);
        send_idle_pct = 6;
        recv_stall_pct = 6;
        test_random_branches(160);

        in_valid <= 1'b0;
        while (segment_results_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatch_cnt == 0 && segment_results_q.size() == 0)
            $display("cylinder_chain_smoother: match");
        else
            $display("cylinder_chain_smoother: mismatch");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
hw/rtl/ccs_pkg.sv
hw/rtl/ccs_front.sv
hw/rtl/ccs_queue.sv
hw/rtl/ccs_back.sv
hw/rtl/cylinder_chain_smoother.sv
verif/cylinder_chain_smoother_tb.sv
